@@ rtl/core/dhti_pkg.sv @@
// Shared types and constants for the double-hashing hash table insert block.
package dhti_pkg;

	localparam int KEY_W   = 31;
	localparam int SLOT_W  = 4;
	localparam int PROBE_W = 5;
	localparam int DIG_W   = 2;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_READ   = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ_RD,
		ST_READ_CHK,
		ST_MOD_KEY,
		ST_LOAD_STEP,
		ST_MOD_STEP,
		ST_PROBE_RD,
		ST_PROBE_CHK,
		ST_DONE
	} dhti_state_t;

	typedef struct packed {
		logic clr_write;
		logic load_req;
		logic mod_step;
		logic load_step;
		logic rd_slot;
		logic record_read;
		logic rd_probe;
		logic probe_next;
		logic write_hit;
		logic record_full;
		logic out_load;
	} dhti_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic mod_last;
		logic hit;
		logic last_probe;
		logic out_free;
	} dhti_sts_t;

endpackage

@@ rtl/core/dhti_rem.sv @@
// Remainder unit: reduces a key by a constant divisor with a reciprocal multiplication.
module dhti_rem
	import dhti_pkg::*;
#(
	parameter int DIVISOR = 7,
	parameter int RW      = $clog2(DIVISOR)
) (
	input  logic             clk,
	input  logic             load,
	input  logic             shift,
	input  logic [KEY_W-1:0] load_val,
	output logic [RW-1:0]    rem
);

	localparam int              LG      = $clog2(DIVISOR);
	localparam int              SH      = KEY_W + LG;
	localparam int              PW      = 2 * KEY_W + 1;
	localparam longint unsigned RECIP   =
		((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam logic [KEY_W:0]  RECIP_V = (KEY_W+1)'(RECIP);

	logic [KEY_W-1:0] val_q;
	logic [PW-1:0]    prod_q;
	logic [RW-1:0]    rem_q;
	logic [KEY_W-1:0] quot;
	logic [KEY_W-1:0] back;
	logic [KEY_W-1:0] diff;

	always_comb begin
		quot = KEY_W'(prod_q >> SH);
		back = quot * KEY_W'(DIVISOR);
		diff = val_q - back;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			val_q <= load_val;
		end
		if (shift) begin
			prod_q <= PW'(val_q) * PW'(RECIP_V);
			rem_q  <= RW'(diff);
		end
	end

	assign rem = rem_q;

endmodule

@@ rtl/core/dhti_ctrl.sv @@
// Controller state machine sequencing clear, hashing, probing and result hand-off.
module dhti_ctrl
	import dhti_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      action,
	input  dhti_sts_t sts,
	output logic      in_stall,
	output dhti_cmd_t cmd
);

	dhti_state_t state_q;
	dhti_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_write = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d = (action == ACT_READ) ? ST_READ_RD : ST_MOD_KEY;
				end
			end
			ST_READ_RD: begin
				cmd.rd_slot = 1'b1;
				state_d = ST_READ_CHK;
			end
			ST_READ_CHK: begin
				cmd.record_read = 1'b1;
				state_d = ST_DONE;
			end
			ST_MOD_KEY: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_last) begin
					state_d = ST_LOAD_STEP;
				end
			end
			ST_LOAD_STEP: begin
				cmd.load_step = 1'b1;
				state_d = ST_MOD_STEP;
			end
			ST_MOD_STEP: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_last) begin
					state_d = ST_PROBE_RD;
				end
			end
			ST_PROBE_RD: begin
				cmd.rd_probe = 1'b1;
				state_d = ST_PROBE_CHK;
			end
			ST_PROBE_CHK: begin
				priority if (sts.hit) begin
					cmd.write_hit = 1'b1;
					state_d = ST_DONE;
				end else if (sts.last_probe) begin
					cmd.record_full = 1'b1;
					state_d = ST_DONE;
				end else begin
					cmd.probe_next = 1'b1;
					state_d = ST_PROBE_RD;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

@@ rtl/core/dhti_datapath.sv @@
// Datapath: slot memory, hash remainders, probe address walk and result registers.
module dhti_datapath
	import dhti_pkg::*;
#(
	parameter int SLOTS        = 16,
	parameter int STEP_MODULUS = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dhti_cmd_t          cmd,
	output dhti_sts_t          sts,
	input  logic [KEY_W-1:0]   key,
	input  logic [SLOT_W-1:0]  slot,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [SLOT_W-1:0]  result_slot,
	output logic [KEY_W-1:0]   result_key,
	output logic               occupied,
	output logic               inserted,
	output logic [PROBE_W-1:0] probes
);

	localparam int SW  = $clog2(SLOTS);
	localparam int CW  = $clog2(SLOTS + 1);
	localparam int BW  = $clog2(STEP_MODULUS);
	localparam int MW  = $clog2(STEP_MODULUS + 1);

	logic [KEY_W:0]      mem [SLOTS];
	logic [KEY_W:0]      rdata_q;
	logic                we;
	logic [SW-1:0]       waddr;
	logic [KEY_W:0]      wdata;
	logic                re;
	logic [SW-1:0]       raddr;

	logic [SW-1:0]       clr_addr_q;
	logic [KEY_W-1:0]    key_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [DIG_W-1:0]    dig_q;
	logic [SW-1:0]       addr_q;
	logic [CW-1:0]       cnt_q;

	logic [SW-1:0]       rem_a;
	logic [BW-1:0]       rem_b;
	logic [MW-1:0]       step_w;
	logic [KEY_W-1:0]    load_a;
	logic [SW:0]         addr_sum;
	logic                rd_in_range;
	logic                rd_occ;

	logic [SLOT_W-1:0]   res_slot_q;
	logic [KEY_W-1:0]    res_key_q;
	logic                res_occ_q;
	logic                res_ins_q;
	logic [PROBE_W-1:0]  res_probes_q;

	logic                out_valid_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic [KEY_W-1:0]    out_key_q;
	logic                out_occ_q;
	logic                out_ins_q;
	logic [PROBE_W-1:0]  out_probes_q;

	assign step_w = MW'(STEP_MODULUS) - MW'(rem_b);
	assign load_a = cmd.load_req ? key : KEY_W'(step_w);

	dhti_rem #(
		.DIVISOR (SLOTS),
		.RW      (SW)
	) u_rem_slots (
		.clk      (clk),
		.load     (cmd.load_req | cmd.load_step),
		.shift    (cmd.mod_step),
		.load_val (load_a),
		.rem      (rem_a)
	);

	dhti_rem #(
		.DIVISOR (STEP_MODULUS),
		.RW      (BW)
	) u_rem_step (
		.clk      (clk),
		.load     (cmd.load_req),
		.shift    (cmd.mod_step),
		.load_val (key),
		.rem      (rem_b)
	);

	always_comb begin
		we    = cmd.clr_write | cmd.write_hit;
		waddr = cmd.clr_write ? clr_addr_q : addr_q;
		wdata = cmd.clr_write ? '0 : {1'b1, key_q};
		re    = cmd.rd_slot | cmd.rd_probe;
		raddr = cmd.rd_slot ? SW'(slot_q) : addr_q;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_write) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	assign addr_sum = {1'b0, addr_q} + {1'b0, rem_a};

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			key_q  <= key;
			slot_q <= slot;
			dig_q  <= DIG_W'(1);
		end else if (cmd.load_step) begin
			dig_q <= DIG_W'(1);
		end else if (cmd.mod_step) begin
			dig_q <= dig_q - 1'b1;
		end
		if (cmd.load_step) begin
			addr_q <= rem_a;
			cnt_q  <= '0;
		end else if (cmd.probe_next) begin
			addr_q <= (addr_sum >= (SW+1)'(SLOTS)) ? SW'(addr_sum - (SW+1)'(SLOTS))
				: SW'(addr_sum);
			cnt_q  <= cnt_q + 1'b1;
		end
	end

	assign rd_in_range = ({{(KEY_W-SLOT_W){1'b0}}, slot_q} < KEY_W'(SLOTS));
	assign rd_occ      = rd_in_range & rdata_q[KEY_W];

	always_ff @(posedge clk) begin
		priority if (cmd.record_read) begin
			res_slot_q   <= slot_q;
			res_key_q    <= rd_occ ? rdata_q[KEY_W-1:0] : '0;
			res_occ_q    <= rd_occ;
			res_ins_q    <= 1'b0;
			res_probes_q <= '0;
		end else if (cmd.write_hit) begin
			res_slot_q   <= SLOT_W'(addr_q);
			res_key_q    <= key_q;
			res_occ_q    <= 1'b0;
			res_ins_q    <= 1'b1;
			res_probes_q <= PROBE_W'(cnt_q + 1'b1);
		end else if (cmd.record_full) begin
			res_slot_q   <= '0;
			res_key_q    <= '0;
			res_occ_q    <= 1'b0;
			res_ins_q    <= 1'b0;
			res_probes_q <= PROBE_W'(SLOTS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_slot_q   <= res_slot_q;
			out_key_q    <= res_key_q;
			out_occ_q    <= res_occ_q;
			out_ins_q    <= res_ins_q;
			out_probes_q <= res_probes_q;
		end
	end

	always_comb begin
		sts.clr_last   = (clr_addr_q == SW'(SLOTS - 1));
		sts.mod_last   = (dig_q == '0);
		sts.hit        = ~rdata_q[KEY_W];
		sts.last_probe = (cnt_q == CW'(SLOTS - 1));
		sts.out_free   = ~out_valid_q | ~out_stall;
	end

	assign out_valid   = out_valid_q;
	assign result_slot = out_slot_q;
	assign result_key  = out_key_q;
	assign occupied    = out_occ_q;
	assign inserted    = out_ins_q;
	assign probes      = out_probes_q;

	a_one_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clr_write && cmd.write_hit))
		else $error("memory written by clear and insert in the same cycle");

	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result loaded over a pending result");

	a_hit_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_hit |-> $past(cmd.rd_probe))
		else $error("insert write without a preceding probe read");

	a_full_after_all: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.record_full |-> (cnt_q == CW'(SLOTS - 1)))
		else $error("table full reported before every probe was made");

endmodule

@@ rtl/core/double_hash_table_insert.sv @@
// Top level of the double-hashing open-addressed hash table with insert and slot read.
//
// Channel   Handshake             Payload
// request   in_valid / in_stall   action, key, slot
// result    out_valid / out_stall result_slot, result_key, occupied, inserted, probes
//
// A read loads its result after a registered slot memory read and a check of the slot.
// An insert reduces the key in the remainder pipeline, loads the step and reduces it,
// then makes a registered slot memory read and a check for each probe. A request is
// accepted only once the previous result is loaded, but a new request is accepted while
// the previous result still waits under out_stall. After reset a clearing pass over the
// slot memory runs with in_stall high.
module double_hash_table_insert
	import dhti_pkg::*;
#(
	parameter int SLOTS        = 16,
	parameter int STEP_MODULUS = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic [KEY_W-1:0]   key,
	input  logic [SLOT_W-1:0]  slot,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [SLOT_W-1:0]  result_slot,
	output logic [KEY_W-1:0]   result_key,
	output logic               occupied,
	output logic               inserted,
	output logic [PROBE_W-1:0] probes
);

	dhti_cmd_t cmd;
	dhti_sts_t sts;

	dhti_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	dhti_datapath #(
		.SLOTS        (SLOTS),
		.STEP_MODULUS (STEP_MODULUS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.key         (key),
		.slot        (slot),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_slot (result_slot),
		.result_key  (result_key),
		.occupied    (occupied),
		.inserted    (inserted),
		.probes      (probes)
	);

endmodule
